### src/qbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbst_pkg
// Shared widths, types, register codes and helpers for the quartic Bezier
// swing trajectory unit.
// ----------------------------------------------------------------------------
package qbst_pkg;

   // field widths
   localparam int PHASE_W   = 17;
   localparam int COORD_W   = 32;
   localparam int CSR_W     = 19;
   localparam int CSR_IDX_W = 2;

   // extra fraction bits carried on control points (Q.20)
   localparam int XF        = 4;
   // control point / curve value width
   localparam int PW        = COORD_W + XF + 1;
   // difference of two curve values
   localparam int DW        = PW + 1;
   // difference times phase
   localparam int PRW       = DW + PHASE_W;
   // difference times velocity gain of 50
   localparam int D50_W     = DW + 6;
   // negated velocity term
   localparam int VN_W      = D50_W + 1;
   // width fed to the output saturation
   localparam int SAT_W     = VN_W - XF;

   localparam int NUM_AXES    = 3;
   localparam int NUM_POINTS  = 5;
   localparam int LEVELS      = NUM_POINTS - 1;
   localparam int LANE_STAGES = 2 * LEVELS;

   localparam logic [PHASE_W-1:0] ONE_Q16  = PHASE_W'(65536);
   localparam logic [PHASE_W-1:0] HALF_Q16 = PHASE_W'(32768);
   // 0.02 in Q1.16; any step up to one half keeps t +/- step inside 0..1
   localparam logic [PHASE_W-1:0] DT_STEP  = PHASE_W'(1311);

   // rounding constants: half an LSB of the shifted result
   localparam logic signed [PRW-1:0]  LERP_RND = PRW'(1) <<< (PHASE_W - 2);
   localparam logic signed [PW-1:0]   POS_RND  = PW'(1) <<< (XF - 1);
   localparam logic signed [VN_W-1:0] VEL_RND  = VN_W'(1) <<< (XF - 1);

   localparam logic signed [CSR_W-1:0] SUB_HEIGHT_RST   = CSR_W'(0);
   localparam logic signed [CSR_W-1:0] SWING_HEIGHT_RST = CSR_W'(26214);
   localparam logic signed [CSR_W-1:0] TOUCHDOWN_RST    = CSR_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUB_HEIGHT       = 2'd0,
      CSR_SWING_HEIGHT     = 2'd1,
      CSR_TOUCHDOWN_OFFSET = 2'd2
   } csr_index_type;

   typedef logic signed [PW-1:0]      point_type;
   typedef logic [PHASE_W-1:0]        phase_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic signed [CSR_W-1:0] sub_height;
      logic signed [CSR_W-1:0] swing_height;
      logic signed [CSR_W-1:0] touchdown_offset;
   } csr_type;

   // clamp to the signed 32-bit range
   function automatic coord_type sat32(input logic signed [SAT_W-1:0] v);
      coord_type r;
      if ((&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1])) begin
         r = v[COORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### src/qbst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbst_req_if / qbst_rsp_if
// Valid/ready channels carrying trajectory queries and curve results.
// ----------------------------------------------------------------------------
interface qbst_req_if
   import qbst_pkg::*;
   ();
   logic      valid;
   logic      ready;
   phase_type phase;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;

   modport source (
      output valid, phase, start_x, start_y, start_z, end_x, end_y, end_z,
      input  ready
   );
   modport sink (
      input  valid, phase, start_x, start_y, start_z, end_x, end_y, end_z,
      output ready
   );
endinterface

interface qbst_rsp_if
   import qbst_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   coord_type vel_x;
   coord_type vel_y;
   coord_type vel_z;

   modport source (
      output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
      output ready
   );
endinterface

### src/qbst_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbst_prep
// Clamps the phase, forms the second phase for the finite difference and
// builds the five Q.20 control points of each axis, registered.
// ----------------------------------------------------------------------------
module qbst_prep
   import qbst_pkg::*;
#(
   parameter phase_type STEP = DT_STEP
)
(
   input  logic      clock,
   input  logic      load,
   input  csr_type   csr,
   input  phase_type phase,
   input  coord_type start_x,
   input  coord_type start_y,
   input  coord_type start_z,
   input  coord_type end_x,
   input  coord_type end_y,
   input  coord_type end_z,
   output point_type pts_ff [NUM_AXES][NUM_POINTS],
   output phase_type t_ff,
   output phase_type t2_ff,
   output logic      neg_ff
);

   point_type pts_in [NUM_AXES][NUM_POINTS];
   phase_type t_in;
   phase_type t2_in;
   logic      neg_in;

   // coordinate scaled to Q.20
   function automatic point_type scale_point(input coord_type c);
      return point_type'({{(PW-COORD_W-XF){c[COORD_W-1]}}, c, {XF{1'b0}}});
   endfunction

   // midpoint of two coordinates in Q.20, exact
   function automatic point_type mid_point(input coord_type s, input coord_type e);
      logic signed [COORD_W:0] sum;
      sum = (COORD_W+1)'(s) + (COORD_W+1)'(e);
      return point_type'({{(PW-COORD_W-XF){sum[COORD_W]}}, sum, {(XF-1){1'b0}}});
   endfunction

   // coordinate plus register offset in Q.20
   function automatic point_type offset_point(input coord_type c,
                                              input logic signed [CSR_W-1:0] off);
      logic signed [COORD_W:0] sum;
      sum = (COORD_W+1)'(c) + (COORD_W+1)'(off);
      return point_type'({sum, {XF{1'b0}}});
   endfunction

   // clamp phase, pick step direction
   always_comb begin
      t_in   = phase[PHASE_W-1] ? ONE_Q16 : phase;
      neg_in = (t_in >= HALF_Q16);
      t2_in  = neg_in ? (t_in - STEP) : (t_in + STEP);
   end

   // control points: x and y share one shape, z takes the offsets
   always_comb begin
      pts_in[0][0] = scale_point(start_x);
      pts_in[0][1] = scale_point(start_x);
      pts_in[0][2] = mid_point(start_x, end_x);
      pts_in[0][3] = scale_point(end_x);
      pts_in[0][4] = scale_point(end_x);

      pts_in[1][0] = scale_point(start_y);
      pts_in[1][1] = scale_point(start_y);
      pts_in[1][2] = mid_point(start_y, end_y);
      pts_in[1][3] = scale_point(end_y);
      pts_in[1][4] = scale_point(end_y);

      pts_in[2][0] = scale_point(start_z);
      pts_in[2][1] = offset_point(start_z, csr.sub_height);
      pts_in[2][2] = offset_point(end_z, csr.swing_height);
      pts_in[2][3] = offset_point(end_z, csr.sub_height);
      pts_in[2][4] = offset_point(end_z, csr.touchdown_offset);
   end

   // hold on stall
   always_ff @(posedge clock) begin
      if (load) begin
         pts_ff <= pts_in;
         t_ff   <= t_in;
         t2_ff  <= t2_in;
         neg_ff <= neg_in;
      end
   end

endmodule

### src/qbst_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbst_lane
// One quartic curve evaluation by de Casteljau's scheme: four levels of
// interpolation, each a multiply stage followed by a round-and-add stage.
// ----------------------------------------------------------------------------
module qbst_lane
   import qbst_pkg::*;
(
   input  logic                   clock,
   input  logic [LANE_STAGES-1:0] load,
   input  point_type              pts [NUM_POINTS],
   input  phase_type              t,
   output point_type              result
);

   // q_ff[k] holds the points after level k-1 (NUM_POINTS-k of them valid)
   point_type q_ff  [1:LEVELS][NUM_POINTS];
   phase_type tq_ff [1:LEVELS-1];

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      localparam int N = LEVELS - k;

      point_type                 src      [N+1];
      phase_type                 tsrc;
      logic signed [PRW-1:0]     prod_in  [N];
      logic signed [PRW-1:0]     prod_ff  [N];
      point_type                 base_ff  [N];
      point_type                 lerp_in  [N];

      // level input: the lane input or the previous level
      for (genvar i = 0; i <= N; i++) begin : g_src
         if (k == 0) begin : g_first
            assign src[i] = pts[i];
         end else begin : g_next
            assign src[i] = q_ff[k][i];
         end
      end
      if (k == 0) begin : g_t_first
         assign tsrc = t;
      end else begin : g_t_next
         assign tsrc = tq_ff[k];
      end

      for (genvar i = 0; i < N; i++) begin : g_pair
         logic signed [DW-1:0]  diff;
         logic signed [PRW-1:0] rsum;

         // multiply the span by t
         assign diff        = DW'(src[i+1]) - DW'(src[i]);
         assign prod_in[i]  = PRW'(diff) * PRW'($signed({1'b0, tsrc}));

         // round to nearest, ties up, and add to the base point
         assign rsum        = prod_ff[i] + LERP_RND;
         assign lerp_in[i]  = PW'(DW'(base_ff[i]) + rsum[PHASE_W-1 +: DW]);

         always_ff @(posedge clock) begin
            if (load[2*k]) begin
               base_ff[i] <= src[i];
               prod_ff[i] <= prod_in[i];
            end
            if (load[2*k+1]) begin
               q_ff[k+1][i] <= lerp_in[i];
            end
         end
      end

      // carry t alongside the points for the next level
      if (k < LEVELS - 1) begin : g_t_carry
         phase_type ta_ff;

         always_ff @(posedge clock) begin
            if (load[2*k]) begin
               ta_ff <= tsrc;
            end
            if (load[2*k+1]) begin
               tq_ff[k+1] <= ta_ff;
            end
         end
      end
   end

   assign result = q_ff[LEVELS][0];

endmodule

### src/qbst_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbst_merge
// Combines the two lanes of each axis: rounds the position, forms the
// finite-difference velocity times 50, signs it and saturates both.
// ----------------------------------------------------------------------------
module qbst_merge
   import qbst_pkg::*;
(
   input  logic       clock,
   input  logic [1:0] load,
   input  point_type  p_now  [NUM_AXES],
   input  point_type  p_step [NUM_AXES],
   input  logic       neg,
   output coord_type  pos_ff [NUM_AXES],
   output coord_type  vel_ff [NUM_AXES]
);

   logic signed [D50_W-1:0] d50_in  [NUM_AXES];
   logic signed [D50_W-1:0] d50_ff  [NUM_AXES];
   coord_type               pos_in  [NUM_AXES];
   coord_type               posm_ff [NUM_AXES];
   coord_type               vel_in  [NUM_AXES];
   logic                    neg_ff;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [DW-1:0]    diff;
      logic signed [D50_W-1:0] dx;
      point_type               psum;
      logic signed [VN_W-1:0]  vn;
      logic signed [VN_W-1:0]  vsum;

      // difference times 50 as 32 + 16 + 2
      assign diff       = DW'(p_step[a]) - DW'(p_now[a]);
      assign dx         = D50_W'(diff);
      assign d50_in[a]  = (dx <<< 5) + (dx <<< 4) + (dx <<< 1);

      // round position to Q16.16 and clamp
      assign psum       = p_now[a] + POS_RND;
      assign pos_in[a]  = sat32(SAT_W'($signed(psum[PW-1:XF])));

      // negate for a backward step, round and clamp
      assign vn         = neg_ff ? -VN_W'(d50_ff[a]) : VN_W'(d50_ff[a]);
      assign vsum       = vn + VEL_RND;
      assign vel_in[a]  = sat32(SAT_W'($signed(vsum[VN_W-1:XF])));
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d50_ff  <= d50_in;
         posm_ff <= pos_in;
         neg_ff  <= neg;
      end
      if (load[1]) begin
         pos_ff <= posm_ff;
         vel_ff <= vel_in;
      end
   end

endmodule

### src/quartic_bezier_swing_trajectory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_bezier_swing_trajectory_unit
// Evaluates a quartic Bezier swing-foot curve per axis at t and at t +/- step
// and returns the Q16.16 position and finite-difference velocity.
// ----------------------------------------------------------------------------
//  channel  role    handshake             carries
//  req      sink    req.valid/req.ready   phase, start_x/y/z, end_x/y/z
//  rsp      source  rsp.valid/rsp.ready   pos_x/y/z, vel_x/y/z
//  csr      write   csr_write_enable      csr_index, csr_write_data
//
// One item per cycle while rsp.ready holds: one stage builds control points,
// six lanes (three axes, two phases) run four de Casteljau levels of two
// stages each, and two merge stages round, difference and saturate.
// Each stage holds under back-pressure and empty stages fill, so items keep
// entering while a finished result waits. Reset clears the stage valids and
// loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module quartic_bezier_swing_trajectory_unit
   import qbst_pkg::*;
#(
   parameter phase_type STEP = DT_STEP
)
(
   input  logic                 clock,
   input  logic                 reset,
   qbst_req_if.sink             req,
   qbst_rsp_if.source           rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   localparam int LANE_FIRST  = 1;
   localparam int MERGE_FIRST = LANE_FIRST + LANE_STAGES;
   localparam int STAGES      = MERGE_FIRST + 2;

   csr_type             csr_ff;
   csr_type             csr_in;
   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   valid_in;
   logic [STAGES-1:0]   load;

   point_type           pts_s0 [NUM_AXES][NUM_POINTS];
   phase_type           t_s0;
   phase_type           t2_s0;
   logic                neg_s0;
   logic                neg_ff [1:LANE_STAGES];
   point_type           p_now  [NUM_AXES];
   point_type           p_step [NUM_AXES];
   coord_type           pos    [NUM_AXES];
   coord_type           vel    [NUM_AXES];

   // register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SUB_HEIGHT:       csr_in.sub_height       = csr_write_data;
            CSR_SWING_HEIGHT:     csr_in.swing_height     = csr_write_data;
            CSR_TOUCHDOWN_OFFSET: csr_in.touchdown_offset = csr_write_data;
            default:              csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sub_height       <= SUB_HEIGHT_RST;
         csr_ff.swing_height     <= SWING_HEIGHT_RST;
         csr_ff.touchdown_offset <= TOUCHDOWN_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // a stage loads when empty or when its item moves on
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   // advance the valid bits
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = (i == 0) ? req.valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = load[0];

   qbst_prep #(
      .STEP (STEP)
   ) u_prep (
      .clock   (clock),
      .load    (load[0]),
      .csr     (csr_ff),
      .phase   (req.phase),
      .start_x (req.start_x),
      .start_y (req.start_y),
      .start_z (req.start_z),
      .end_x   (req.end_x),
      .end_y   (req.end_y),
      .end_z   (req.end_z),
      .pts_ff  (pts_s0),
      .t_ff    (t_s0),
      .t2_ff   (t2_s0),
      .neg_ff  (neg_s0)
   );

   // carry the step direction past the lanes
   for (genvar j = 1; j <= LANE_STAGES; j++) begin : g_neg
      always_ff @(posedge clock) begin
         if (load[LANE_FIRST + j - 1]) begin
            neg_ff[j] <= (j == 1) ? neg_s0 : neg_ff[(j == 1) ? 1 : j - 1];
         end
      end
   end

   // one lane per axis and phase
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      qbst_lane u_lane_now (
         .clock  (clock),
         .load   (load[LANE_FIRST +: LANE_STAGES]),
         .pts    (pts_s0[a]),
         .t      (t_s0),
         .result (p_now[a])
      );
      qbst_lane u_lane_step (
         .clock  (clock),
         .load   (load[LANE_FIRST +: LANE_STAGES]),
         .pts    (pts_s0[a]),
         .t      (t2_s0),
         .result (p_step[a])
      );
   end

   qbst_merge u_merge (
      .clock  (clock),
      .load   (load[MERGE_FIRST +: 2]),
      .p_now  (p_now),
      .p_step (p_step),
      .neg    (neg_ff[LANE_STAGES]),
      .pos_ff (pos),
      .vel_ff (vel)
   );

   assign rsp.valid = valid_ff[STAGES-1];
   assign rsp.pos_x = pos[0];
   assign rsp.pos_y = pos[1];
   assign rsp.pos_z = pos[2];
   assign rsp.vel_x = vel[0];
   assign rsp.vel_y = vel[1];
   assign rsp.vel_z = vel[2];

   // second phase sits one step away in the chosen direction
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> ((neg_s0 && (t_s0 - t2_s0) == STEP) ||
                       (!neg_s0 && (t2_s0 - t_s0) == STEP)))
      else $error("second phase is not one step from the first");

   // direction follows the half-way point
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (neg_s0 == (t_s0 >= HALF_Q16)))
      else $error("step direction does not match the phase");

   // both phases stay within zero to one
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (t_s0 <= ONE_Q16 && t2_s0 <= ONE_Q16))
      else $error("phase left the unit interval");

endmodule

### verif/tb_quartic_bezier_swing_trajectory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quartic_bezier_swing_trajectory_unit
// Self-checking bench for the swing-foot trajectory unit. A queue of queries
// (directed corner cases, then random ones) feeds a bursty driver. Each
// accepted query is evaluated by a fixed-point de Casteljau predictor in the
// bench, and a monitor behind a stalling receiver compares every result field
// against the oldest predicted trajectory. Register settings change between
// drained phases, covering defaults, both extremes and random values.
// ----------------------------------------------------------------------------
module tb_quartic_bezier_swing_trajectory_unit;
   import qbst_pkg::*;

   localparam longint VEL_GAIN    = 50;
   localparam longint Q20_SCALE   = longint'(1) <<< XF;
   localparam longint COORD_MAX   = (longint'(1) <<< 31) - 1;
   localparam longint COORD_MIN   = -(longint'(1) <<< 31);
   localparam int     CSR_MAX     = 131072;
   localparam int     HOLD_CYCLES = 200;
   localparam int     REPORT_CAP  = 100;

   typedef struct {
      phase_type phase;
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } swing_query_type;

   typedef struct {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      coord_type vel_x;
      coord_type vel_y;
      coord_type vel_z;
   } swing_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   qbst_req_if req_ch ();
   qbst_rsp_if rsp_ch ();

   quartic_bezier_swing_trajectory_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // bench copy of the height registers
   longint model_sub_height   = SUB_HEIGHT_RST;
   longint model_swing_height = SWING_HEIGHT_RST;
   longint model_touchdown    = TOUCHDOWN_RST;

   swing_query_type  pending_queries [$];
   swing_result_type due_trajectories [$];
   swing_query_type  offered_query;

   int  queries_queued   = 0;
   int  queries_accepted = 0;
   int  results_checked  = 0;
   int  mismatch_count   = 0;
   bit  hold_request     = 1'b0;
   bit  long_hold        = 1'b0;
   int  burst_left       = 0;
   int  gap_left         = 0;
   int  stall_left       = 0;
   int  stall_mode       = 0;

   // ------------------------------------------------------------------------
   // Trajectory predictor
   // ------------------------------------------------------------------------

   // divide by 2^s, round to nearest with ties toward plus infinity
   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint lerp_q20(input longint a, input longint b,
                                      input longint t);
      return a + round_half_up((b - a) * t, 16);
   endfunction

   function automatic longint bezier_q20(input longint cp [NUM_POINTS],
                                         input longint t);
      longint q [NUM_POINTS];
      q = cp;
      for (int k = LEVELS; k > 0; k--) begin
         for (int i = 0; i < k; i++) begin
            q[i] = lerp_q20(q[i], q[i + 1], t);
         end
      end
      return q[0];
   endfunction

   function automatic coord_type clamp_q16(input longint v);
      if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(v);
   endfunction

   function automatic swing_result_type predict_swing(input swing_query_type q);
      longint           t_now;
      longint           t_probe;
      bit               descending;
      longint           cp [NUM_AXES][NUM_POINTS];
      longint           s_pt [NUM_AXES];
      longint           e_pt [NUM_AXES];
      longint           here;
      longint           there;
      longint           slope;
      coord_type        pos [NUM_AXES];
      coord_type        vel [NUM_AXES];
      swing_result_type r;

      // clamp phase to one, pick the probe direction
      t_now = longint'(q.phase);
      if (t_now > longint'(ONE_Q16)) begin
         t_now = longint'(ONE_Q16);
      end
      descending = (t_now >= longint'(HALF_Q16));
      t_probe = descending ? t_now - longint'(DT_STEP) : t_now + longint'(DT_STEP);
      if (t_probe < 0) begin
         t_probe = 0;
      end
      if (t_probe > longint'(ONE_Q16)) begin
         t_probe = longint'(ONE_Q16);
      end

      s_pt[0] = longint'(q.start_x);
      s_pt[1] = longint'(q.start_y);
      s_pt[2] = longint'(q.start_z);
      e_pt[0] = longint'(q.end_x);
      e_pt[1] = longint'(q.end_y);
      e_pt[2] = longint'(q.end_z);

      // planar axes: start, start, midpoint, end, end
      for (int a = 0; a < 2; a++) begin
         cp[a][0] = s_pt[a] * Q20_SCALE;
         cp[a][1] = s_pt[a] * Q20_SCALE;
         cp[a][2] = (s_pt[a] * Q20_SCALE + e_pt[a] * Q20_SCALE) / 2;
         cp[a][3] = e_pt[a] * Q20_SCALE;
         cp[a][4] = e_pt[a] * Q20_SCALE;
      end
      // vertical axis: lift off, apex, set down
      cp[2][0] = s_pt[2] * Q20_SCALE;
      cp[2][1] = (s_pt[2] + model_sub_height) * Q20_SCALE;
      cp[2][2] = (e_pt[2] + model_swing_height) * Q20_SCALE;
      cp[2][3] = (e_pt[2] + model_sub_height) * Q20_SCALE;
      cp[2][4] = (e_pt[2] + model_touchdown) * Q20_SCALE;

      for (int a = 0; a < NUM_AXES; a++) begin
         here  = bezier_q20(cp[a], t_now);
         there = bezier_q20(cp[a], t_probe);
         slope = (there - here) * VEL_GAIN;
         if (descending) begin
            slope = -slope;
         end
         pos[a] = clamp_q16(round_half_up(here, XF));
         vel[a] = clamp_q16(round_half_up(slope, XF));
      end

      r.pos_x = pos[0];
      r.pos_y = pos[1];
      r.pos_z = pos[2];
      r.vel_x = vel[0];
      r.vel_y = vel[1];
      r.vel_z = vel[2];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic swing_query_type make_query(input int unsigned ph,
                                                  input int sx, input int sy,
                                                  input int sz, input int ex,
                                                  input int ey, input int ez);
      swing_query_type q;
      q.phase   = phase_type'(ph);
      q.start_x = coord_type'(sx);
      q.start_y = coord_type'(sy);
      q.start_z = coord_type'(sz);
      q.end_x   = coord_type'(ex);
      q.end_y   = coord_type'(ey);
      q.end_z   = coord_type'(ez);
      return q;
   endfunction

   function automatic phase_type random_phase();
      case ($urandom_range(0, 9))
         0: return phase_type'($urandom_range(65537, 131071));
         1: begin
            case ($urandom_range(0, 4))
               0:       return phase_type'(0);
               1:       return phase_type'(32767);
               2:       return phase_type'(32768);
               3:       return phase_type'(65535);
               default: return phase_type'(65536);
            endcase
         end
         default: return phase_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 5))
         0, 1:    return coord_type'($urandom());
         2, 3:    return coord_type'(int'($urandom_range(0, 524288)) - 262144);
         4:       return coord_type'(COORD_MAX - longint'($urandom_range(0, 1000)));
         default: return coord_type'(COORD_MIN + longint'($urandom_range(0, 1000)));
      endcase
   endfunction

   function automatic int random_height();
      return int'($urandom_range(0, 2 * CSR_MAX)) - CSR_MAX;
   endfunction

   task automatic queue_query(input swing_query_type q);
      pending_queries.push_back(q);
      queries_queued++;
   endtask

   task automatic queue_random(input int count);
      swing_query_type q;
      for (int n = 0; n < count; n++) begin
         q.phase   = random_phase();
         q.start_x = random_coord();
         q.start_y = random_coord();
         q.start_z = random_coord();
         // a realistic step: end close to start
         if ($urandom_range(0, 2) == 0) begin
            q.end_x = q.start_x + coord_type'(int'($urandom_range(0, 131072)) - 65536);
            q.end_y = q.start_y + coord_type'(int'($urandom_range(0, 131072)) - 65536);
            q.end_z = q.start_z + coord_type'(int'($urandom_range(0, 32768)) - 16384);
         end else begin
            q.end_x = random_coord();
            q.end_y = random_coord();
            q.end_z = random_coord();
         end
         queue_query(q);
      end
   endtask

   // wait for every queued item to be accepted and its result checked
   task automatic wait_drained();
      while (queries_accepted != queries_queued || due_trajectories.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_W'(value);
      case (idx)
         CSR_SUB_HEIGHT:   model_sub_height   = value;
         CSR_SWING_HEIGHT: model_swing_height = value;
         default:          model_touchdown    = value;
      endcase
   endtask

   task automatic apply_heights(input int sub_h, input int swing_h, input int touch_h);
      wait_drained();
      write_register(CSR_SUB_HEIGHT, sub_h);
      write_register(CSR_SWING_HEIGHT, swing_h);
      write_register(CSR_TOUCHDOWN_OFFSET, touch_h);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_mismatch(input string msg);
      // keep the log readable on a badly broken build
      if (mismatch_count < REPORT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string label, input coord_type got,
                              input coord_type want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   results_checked, label, got, want));
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock and time limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : run_limit
      #2_000_000;
      $display("quartic_bezier_swing_trajectory_unit regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Query driver: bursts of items with random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : query_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_trajectories.push_back(predict_swing(offered_query));
            queries_accepted++;
         end
         // hold an item that is still waiting, else advance
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_queries.size() > 0) begin
               offered_query = pending_queries.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.phase   <= offered_query.phase;
               req_ch.start_x <= offered_query.start_x;
               req_ch.start_y <= offered_query.start_y;
               req_ch.start_z <= offered_query.start_z;
               req_ch.end_x   <= offered_query.end_x;
               req_ch.end_y   <= offered_query.end_y;
               req_ch.end_z   <= offered_query.end_z;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: stalls on its own pattern and checks each item
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      swing_result_type want;
      bit               take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         stall_mode = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_trajectories.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_checked));
            end else begin
               want = due_trajectories.pop_front();
               check_field("pos_x", rsp_ch.pos_x, want.pos_x);
               check_field("pos_y", rsp_ch.pos_y, want.pos_y);
               check_field("pos_z", rsp_ch.pos_z, want.pos_z);
               check_field("vel_x", rsp_ch.vel_x, want.vel_x);
               check_field("vel_y", rsp_ch.vel_y, want.vel_y);
               check_field("vel_z", rsp_ch.vel_z, want.vel_z);
            end
            results_checked++;
         end
         // switch between always ready, light and heavy stalling
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 60);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       take = 1'b1;
            1:       take = ($urandom_range(0, 3) != 0);
            default: take = ($urandom_range(0, 9) < 3);
         endcase
         rsp_ch.ready <= take && !long_hold;
      end
   end

   // ------------------------------------------------------------------------
   // Long receiver hold-off so the pipeline fills and stalls its input
   // ------------------------------------------------------------------------
   initial begin : receiver_hold
      wait (hold_request);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SUB_HEIGHT;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.phase     = '0;
      req_ch.start_x   = '0;
      req_ch.start_y   = '0;
      req_ch.start_z   = '0;
      req_ch.end_x     = '0;
      req_ch.end_y     = '0;
      req_ch.end_z     = '0;
      rsp_ch.ready     = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default heights: phase corners, phase above one, extremes, rounding
      queue_query(make_query(0, 0, 0, 0, 0, 0, 0));
      queue_query(make_query(0, 65536, -65536, 0, 131072, 65536, 0));
      queue_query(make_query(1, 65536, -65536, 0, 131072, 65536, 0));
      queue_query(make_query(16384, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(32767, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(32768, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(32769, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(65535, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(65536, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(65537, -30000, 12000, -5000, 40000, -7000, 3000));
      queue_query(make_query(131071, 7, -7, 9, -9, 11, -11));
      queue_query(make_query(16384, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000));
      queue_query(make_query(49152, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      queue_query(make_query(32768, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      queue_query(make_query(0, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000));
      queue_query(make_query(65536, 32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h80000000, 32'h7fffffff, 32'h80000000));
      queue_query(make_query(32768, -1, 1, -1, 1, -1, 1));
      queue_query(make_query(12345, 0, 1, 0, 1, 0, 1));
      queue_query(make_query(1311, -3, 5, 2, 3, -5, -2));
      queue_query(make_query(64225, -3, 5, 2, 3, -5, -2));
      queue_random(130);

      // all heights at the top of their range
      apply_heights(CSR_MAX, CSR_MAX, CSR_MAX);
      queue_query(make_query(32768, 32'h7fffffff, 0, 32'h7fffffff, 0, 0, 32'h7fffffff));
      queue_query(make_query(65536, 0, 0, 32'h7ffe0000, 0, 0, 32'h7ffe0000));
      queue_query(make_query(0, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000));
      queue_random(130);

      // all heights at the bottom of their range
      apply_heights(-CSR_MAX, -CSR_MAX, -CSR_MAX);
      queue_query(make_query(32768, 0, 0, 32'h80000000, 0, 0, 32'h80000000));
      queue_query(make_query(65536, 0, 0, 32'h80010000, 0, 0, 32'h80010000));
      queue_query(make_query(20000, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff));
      queue_random(130);

      // random heights, with the long receiver hold-off
      apply_heights(random_height(), random_height(), random_height());
      queue_random(300);
      hold_request = 1'b1;

      // mixed extremes
      apply_heights(-CSR_MAX, CSR_MAX, 0);
      queue_random(130);

      wait_drained();
      repeat (30) @(posedge clock);
      if (due_trajectories.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", due_trajectories.size()));
      end
      if (mismatch_count == 0) begin
         $display("quartic_bezier_swing_trajectory_unit regression: pass");
      end else begin
         $display("quartic_bezier_swing_trajectory_unit regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
src/qbst_pkg.sv
src/qbst_if.sv
src/qbst_prep.sv
src/qbst_lane.sv
src/qbst_merge.sv
src/quartic_bezier_swing_trajectory_unit.sv
verif/tb_quartic_bezier_swing_trajectory_unit.sv
